// File: rtl/core/tlib_pkg.sv
// Shared types and constants of the text line index builder.
// No dependencies; imported by every module of the block.
package tlib_pkg;

    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_END = 8'h00;

    localparam logic REG_MAX_LINES   = 1'b0;
    localparam logic REG_MAX_COLUMNS = 1'b1;

    localparam logic [15:0] MAX_LINES_RST   = 16'd4096;
    localparam logic [15:0] MAX_COLUMNS_RST = 16'd256;

    localparam int EQ_DEPTH = 4;
    localparam int EQ_AW    = $clog2(EQ_DEPTH);
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);

    localparam logic KIND_LINE    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_OVF   = 1'b1;

    typedef enum logic [1:0] {
        EV_CHAR,
        EV_EOL,
        EV_SKIP,
        EV_END
    } ev_code_t;

    typedef struct packed {
        logic     wr;
        ev_code_t code;
    } ev_wr_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] line_index;
        logic [15:0] start_offset;
        logic [15:0] line_bytes;
        logic [15:0] line_total;
        logic        status;
        logic        last;
    } rec_t;

    typedef struct packed {
        logic [OQ_AW:0] oq_count;
    } back_stat_t;

endpackage

// File: rtl/core/tlib_front.sv
// Front end: accepts text bytes and classifies them into line events.
// Depends on tlib_pkg; feeds tlib_evq.
module tlib_front
    import tlib_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic [7:0] char_byte,
    input  logic       evq_full,
    output logic       full,
    output ev_wr_t     ev_wr
);

    logic prev_cr_reg;
    logic prev_cr_next;
    logic accept;

    assign accept = push & ~evq_full;
    assign full   = evq_full;

    always_comb
    begin
        ev_wr.wr = accept;
        if (char_byte == CH_END)
            ev_wr.code = EV_END;
        else if (char_byte == CH_LF && prev_cr_reg)
            ev_wr.code = EV_SKIP;
        else if (char_byte == CH_CR || char_byte == CH_LF)
            ev_wr.code = EV_EOL;
        else
            ev_wr.code = EV_CHAR;
    end

    // CR state is only meaningful while no overflow, so track it unconditionally
    assign prev_cr_next = accept ? (char_byte == CH_CR) : prev_cr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prev_cr_reg <= 1'b0;
        else
            prev_cr_reg <= prev_cr_next;
    end

endmodule

// File: rtl/core/tlib_evq.sv
// Short event queue between the front end and the back end.
// Depends on tlib_pkg.
module tlib_evq
    import tlib_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  ev_wr_t   ev_wr,
    input  logic     rd,
    output logic     empty,
    output logic     full,
    output ev_code_t head
);

    ev_code_t         mem_reg [EQ_DEPTH];
    logic [EQ_AW-1:0] wptr_reg, wptr_next;
    logic [EQ_AW-1:0] rptr_reg, rptr_next;
    logic [EQ_AW:0]   count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == (EQ_AW+1)'(EQ_DEPTH));
    assign head  = mem_reg[rptr_reg];
    assign do_wr = ev_wr.wr & ~full;
    assign do_rd = rd & ~empty;

    always_comb
    begin
        wptr_next  = do_wr ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = do_rd ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg + (EQ_AW+1)'(do_wr) - (EQ_AW+1)'(do_rd);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wptr_reg] <= ev_wr.code;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

// File: rtl/core/tlib_back.sv
// Back end: line state, record generation and the result queue.
// Depends on tlib_pkg; reads events from tlib_evq.
module tlib_back
    import tlib_pkg::*;
#(
    parameter int OFFSET_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] max_lines,
    input  logic [15:0] max_columns,
    input  logic        ev_empty,
    input  ev_code_t    ev_code,
    output logic        ev_rd,
    input  logic        pop,
    output logic        empty,
    output rec_t        head,
    output back_stat_t  stat
);

    localparam int CW = (OFFSET_BITS > 16) ? OFFSET_BITS : 16;
    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

    logic [OFFSET_BITS-1:0] off_reg, off_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [15:0]            lines_reg, lines_next;
    logic                   ovf_reg, ovf_next;

    rec_t             oq_mem_reg [OQ_DEPTH];
    logic [OQ_AW-1:0] oq_wptr_reg, oq_wptr_next;
    logic [OQ_AW-1:0] oq_rptr_reg, oq_rptr_next;
    logic [OQ_AW:0]   oq_count_reg, oq_count_next;

    logic                   take;
    logic                   do_pop;
    logic [OFFSET_BITS-1:0] len;
    logic [OFFSET_BITS-1:0] off_inc;
    logic                   close_bad;
    logic [15:0]            lines_end;
    logic                   ovf_end;
    logic [1:0]             n_wr;
    rec_t                   rec0, rec1;
    rec_t                   line_rec;
    rec_t                   sum_rec;

    assign take    = ~ev_empty && (oq_count_reg <= (OQ_AW+1)'(OQ_DEPTH - 2));
    assign ev_rd   = take;
    assign empty   = (oq_count_reg == '0);
    assign do_pop  = pop & ~empty;
    assign head    = oq_mem_reg[oq_rptr_reg];
    assign stat.oq_count = oq_count_reg;

    assign len     = off_reg - start_reg;
    assign off_inc = off_reg + 1'b1;
    // line too long, or recording it would reach the line limit
    assign close_bad = (CW'(len) > CW'(max_columns)) ||
                       (({1'b0, lines_reg} + 17'd1) >= {1'b0, max_lines});

    always_comb
    begin
        line_rec.kind         = KIND_LINE;
        line_rec.line_index   = lines_reg;
        line_rec.start_offset = 16'(start_reg);
        line_rec.line_bytes   = 16'(len);
        line_rec.line_total   = '0;
        line_rec.status       = STATUS_OK;
        line_rec.last         = 1'b0;
    end

    always_comb
    begin
        off_next   = off_reg;
        start_next = start_reg;
        lines_next = lines_reg;
        ovf_next   = ovf_reg;
        n_wr       = 2'd0;
        rec0       = line_rec;
        rec1       = line_rec;
        lines_end  = lines_reg;
        ovf_end    = ovf_reg;
        sum_rec    = line_rec;

        if (take)
        begin
            case (ev_code)
                EV_END:
                begin
                    // trailing line with no terminator
                    if (!ovf_reg && (start_reg < off_reg))
                    begin
                        if (close_bad)
                            ovf_end = 1'b1;
                        else
                        begin
                            lines_end = lines_reg + 16'd1;
                            n_wr      = 2'd1;
                        end
                    end
                    if (lines_end >= max_lines)
                        ovf_end = 1'b1;
                    sum_rec.kind         = KIND_SUMMARY;
                    sum_rec.line_index   = '0;
                    sum_rec.start_offset = '0;
                    sum_rec.line_bytes   = '0;
                    sum_rec.line_total   = lines_end;
                    sum_rec.status       = ovf_end ? STATUS_OVF : STATUS_OK;
                    sum_rec.last         = 1'b1;
                    if (n_wr == 2'd1)
                    begin
                        rec1 = sum_rec;
                        n_wr = 2'd2;
                    end
                    else
                    begin
                        rec0 = sum_rec;
                        n_wr = 2'd1;
                    end
                    off_next   = '0;
                    start_next = '0;
                    lines_next = '0;
                    ovf_next   = 1'b0;
                end
                EV_SKIP, EV_EOL, EV_CHAR:
                begin
                    if (ovf_reg)
                    begin
                        // silent until end of text
                    end
                    else if (off_reg == OFFSET_MAX)
                        ovf_next = 1'b1;
                    else
                    begin
                        off_next = off_inc;
                        if (ev_code == EV_SKIP)
                            start_next = off_inc;
                        else if (ev_code == EV_EOL)
                        begin
                            start_next = off_inc;
                            if (close_bad)
                                ovf_next = 1'b1;
                            else
                            begin
                                n_wr       = 2'd1;
                                lines_next = lines_reg + 16'd1;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        oq_wptr_next  = oq_wptr_reg + OQ_AW'(n_wr);
        oq_rptr_next  = do_pop ? oq_rptr_reg + 1'b1 : oq_rptr_reg;
        oq_count_next = oq_count_reg + (OQ_AW+1)'(n_wr) - (OQ_AW+1)'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (n_wr != 2'd0)
            oq_mem_reg[oq_wptr_reg] <= rec0;
        if (n_wr == 2'd2)
            oq_mem_reg[oq_wptr_reg + 1'b1] <= rec1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg      <= '0;
            start_reg    <= '0;
            lines_reg    <= '0;
            ovf_reg      <= 1'b0;
            oq_wptr_reg  <= '0;
            oq_rptr_reg  <= '0;
            oq_count_reg <= '0;
        end
        else
        begin
            off_reg      <= off_next;
            start_reg    <= start_next;
            lines_reg    <= lines_next;
            ovf_reg      <= ovf_next;
            oq_wptr_reg  <= oq_wptr_next;
            oq_rptr_reg  <= oq_rptr_next;
            oq_count_reg <= oq_count_next;
        end
    end

endmodule

// File: rtl/core/text_line_index_builder.sv
// A byte accepted is written to the event queue, then stepped by the back end into the result queue.
// Throughput: one byte per cycle unless a queue fills; the end byte yields up to two words, drained one per pop.
// The rate is set by the single-event-per-cycle step of the back end line state.
// Reset clears offsets, line count, overflow and both queues; max_lines returns to 4096,
// max_columns to 256.
module text_line_index_builder
    import tlib_pkg::*;
#(
    parameter int OFFSET_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  char_byte,
    output logic        empty,
    input  logic        pop,
    output logic        record_kind,
    output logic [15:0] line_index,
    output logic [15:0] start_offset,
    output logic [15:0] line_bytes,
    output logic [15:0] line_total,
    output logic        status,
    output logic        last
);

    logic [15:0] max_lines_reg;
    logic [15:0] max_columns_reg;

    ev_wr_t     ev_wr;
    logic       evq_full;
    logic       evq_empty;
    logic       evq_rd;
    ev_code_t   evq_head;
    rec_t       head;
    back_stat_t back_stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_lines_reg   <= MAX_LINES_RST;
            max_columns_reg <= MAX_COLUMNS_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_MAX_LINES:   max_lines_reg   <= cfg_wdata;
                REG_MAX_COLUMNS: max_columns_reg <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    tlib_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .char_byte (char_byte),
        .evq_full  (evq_full),
        .full      (full),
        .ev_wr     (ev_wr)
    );

    tlib_evq u_evq (
        .clk   (clk),
        .rst_n (rst_n),
        .ev_wr (ev_wr),
        .rd    (evq_rd),
        .empty (evq_empty),
        .full  (evq_full),
        .head  (evq_head)
    );

    tlib_back #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .max_lines   (max_lines_reg),
        .max_columns (max_columns_reg),
        .ev_empty    (evq_empty),
        .ev_code     (evq_head),
        .ev_rd       (evq_rd),
        .pop         (pop),
        .empty       (empty),
        .head        (head),
        .stat        (back_stat)
    );

    assign record_kind  = head.kind;
    assign line_index   = head.line_index;
    assign start_offset = head.start_offset;
    assign line_bytes   = head.line_bytes;
    assign line_total   = head.line_total;
    assign status       = head.status;
    assign last         = head.last;

`ifndef SYNTHESIS
    a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        back_stat.oq_count <= (OQ_AW+1)'(OQ_DEPTH))
        else $error("result queue count beyond depth");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        push && !full |=> !evq_empty)
        else $error("accepted byte missing from event queue");

    a_last_is_summary: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (last == record_kind))
        else $error("last flag disagrees with record kind");

    a_line_rec_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && record_kind == KIND_LINE |-> line_total == '0 && status == STATUS_OK)
        else $error("line word carries summary fields");
`endif

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for text_line_index_builder: drives text bytes through the push/full
// side and checks every popped word against a line-splitting predictor kept in step here.
// Depends on tlib_pkg and the text_line_index_builder RTL only.
module testbench;
    import tlib_pkg::*;

    localparam int OFFSET_LIMIT = 65535;    // largest byte offset with 16 offset bits
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASE_BYTES  = 300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = REG_MAX_LINES;
    logic [15:0] cfg_wdata = '0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  char_byte = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic        record_kind;
    logic [15:0] line_index;
    logic [15:0] start_offset;
    logic [15:0] line_bytes;
    logic [15:0] line_total;
    logic        status;
    logic        last;

    text_line_index_builder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .push         (push),
        .full         (full),
        .char_byte    (char_byte),
        .empty        (empty),
        .pop          (pop),
        .record_kind  (record_kind),
        .line_index   (line_index),
        .start_offset (start_offset),
        .line_bytes   (line_bytes),
        .line_total   (line_total),
        .status       (status),
        .last         (last)
    );

    // line splitter state, mirrored from the block
    logic [15:0] max_lines_cfg = MAX_LINES_RST;
    logic [15:0] max_columns_cfg = MAX_COLUMNS_RST;
    int          text_offset = 0;
    int          line_begin = 0;
    int          lines_found = 0;
    bit          after_cr = 1'b0;
    bit          text_rejected = 1'b0;

    rec_t        pending_records[$];
    rec_t        head_rec;
    bit          no_idle = 1'b0;
    int          cycle_count = 0;
    int          items_sent = 0;
    int          mismatches = 0;
    int          lines_checked = 0;
    int          texts_checked = 0;
    int          rejected_texts = 0;
    int          settings_applied = 0;

    initial begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge clk);
        $display("FAILURE");
        $finish;
    end

    function automatic void close_current_line();
        int   len;
        rec_t r;
        len = text_offset - line_begin;
        if (len > max_columns_cfg || lines_found + 1 >= max_lines_cfg) begin
            text_rejected = 1'b1;
        end else begin
            r = '0;
            r.kind = KIND_LINE;
            r.line_index = lines_found[15:0];
            r.start_offset = line_begin[15:0];
            r.line_bytes = len[15:0];
            pending_records.push_back(r);
            lines_found++;
        end
    endfunction

    function automatic void index_byte(logic [7:0] b);
        rec_t r;
        if (b == CH_END) begin
            if (!text_rejected && line_begin < text_offset)
                close_current_line();
            if (lines_found >= max_lines_cfg)
                text_rejected = 1'b1;
            r = '0;
            r.kind = KIND_SUMMARY;
            r.line_total = lines_found[15:0];
            r.status = text_rejected ? STATUS_OVF : STATUS_OK;
            r.last = 1'b1;
            pending_records.push_back(r);
            text_offset = 0;
            line_begin = 0;
            lines_found = 0;
            after_cr = 1'b0;
            text_rejected = 1'b0;
        end else if (text_rejected) begin
            // silent until the end byte
        end else if (text_offset >= OFFSET_LIMIT) begin
            text_rejected = 1'b1;
        end else if (b == CH_LF && after_cr) begin
            text_offset++;
            line_begin = text_offset;
            after_cr = 1'b0;
        end else if (b == CH_CR || b == CH_LF) begin
            close_current_line();
            text_offset++;
            line_begin = text_offset;
            after_cr = (b == CH_CR);
        end else begin
            text_offset++;
            after_cr = 1'b0;
        end
    endfunction

    // push stays high on return so back-to-back bytes need no extra edge;
    // anything that waits without sending must drop it first
    task automatic send_byte(logic [7:0] b);
        while (!no_idle && $urandom_range(99) < 13) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        char_byte <= b;
        do @(posedge clk); while (full);
        index_byte(b);
        items_sent++;
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (pending_records.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_limits(logic [15:0] lines, logic [15:0] cols);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_MAX_LINES;
        cfg_wdata <= lines;
        @(posedge clk);
        cfg_index <= REG_MAX_COLUMNS;
        cfg_wdata <= cols;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        max_lines_cfg = lines;
        max_columns_cfg = cols;
        settings_applied++;
    endtask

    // '^' stands for CR and '/' for LF; the end byte is appended
    task automatic send_text(string s);
        logic [7:0] b;
        for (int i = 0; i < s.len(); i++) begin
            b = s[i];
            if (b == "^")
                b = CH_CR;
            else if (b == "/")
                b = CH_LF;
            send_byte(b);
        end
        send_byte(CH_END);
    endtask

    function automatic logic [7:0] text_char();
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255)); while (b == CH_CR || b == CH_LF);
        return b;
    endfunction

    function automatic int line_len();
        if (max_columns_cfg <= 40 && $urandom_range(3) == 0)
            return int'(max_columns_cfg) + $urandom_range(1);
        return $urandom_range(0, 12);
    endfunction

    task automatic send_random_text();
        int n_lines;
        if ($urandom_range(9) == 0) begin
            // raw noise: any byte but the end marker
            repeat ($urandom_range(1, 30)) send_byte(8'($urandom_range(1, 255)));
        end else begin
            n_lines = $urandom_range(0, 6);
            for (int i = 0; i < n_lines; i++) begin
                repeat (line_len()) send_byte(text_char());
                case ($urandom_range(2))
                    0: send_byte(CH_CR);
                    1: send_byte(CH_LF);
                    default: begin
                        send_byte(CH_CR);
                        send_byte(CH_LF);
                    end
                endcase
            end
            if ($urandom_range(1))
                repeat (line_len()) send_byte(text_char());
        end
        send_byte(CH_END);
    endtask

    task automatic test_terminators();
        send_text("");
        send_text("ab^/cd/^e");
        send_text("^^/x");
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(8'h01);
        send_text("/");
        wait_idle();
    endtask

    task automatic test_line_limit();
        set_limits(16'd2, MAX_COLUMNS_RST);
        send_text("a/b/c");
        set_limits(16'd1, MAX_COLUMNS_RST);
        send_text("");
        send_text("x");
        wait_idle();
    endtask

    task automatic test_column_limit();
        set_limits(MAX_LINES_RST, 16'd1);
        send_text("a/bc^/d");
        send_text("/");
        wait_idle();
    endtask

    task automatic test_random_texts();
        int quota;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_limits(MAX_LINES_RST, MAX_COLUMNS_RST);
                1: set_limits(16'd3, 16'd4);
                2: set_limits(16'd1, 16'd1);
                3: set_limits(16'hFFFF, 16'hFFFF);
                4: set_limits(16'($urandom_range(2, 10)), 16'($urandom_range(1, 16)));
                default: set_limits(16'($urandom_range(1, 65535)),
                                    16'($urandom_range(1, 65535)));
            endcase
            no_idle = (phase == 0);
            quota = items_sent + PHASE_BYTES;
            while (items_sent < quota) send_random_text();
            wait_idle();
        end
        no_idle = 1'b0;
    endtask

    always @(posedge clk) begin
        pop <= no_idle ? 1'b1 : ($urandom_range(99) >= 13);
    end

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk) begin
        if (rst_n && pop && !empty) begin
            if (pending_records.size() == 0) begin
                $error("unexpected word: kind %0d line %0d total %0d",
                       record_kind, line_index, line_total);
                mismatches++;
            end else begin
                head_rec = pending_records.pop_front();
                check_field("record_kind", head_rec.kind, record_kind);
                check_field("line_index", head_rec.line_index, line_index);
                check_field("start_offset", head_rec.start_offset, start_offset);
                check_field("line_bytes", head_rec.line_bytes, line_bytes);
                check_field("line_total", head_rec.line_total, line_total);
                check_field("status", head_rec.status, status);
                check_field("last", head_rec.last, last);
                if (head_rec.kind == KIND_SUMMARY) begin
                    texts_checked++;
                    if (head_rec.status == STATUS_OVF)
                        rejected_texts++;
                end else begin
                    lines_checked++;
                end
            end
        end
    end

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_terminators();
        test_line_limit();
        test_column_limit();
        test_random_texts();
        wait_idle();
        $display("Sent %0d bytes in %0d cycles under %0d limit settings.",
                 items_sent, cycle_count, settings_applied);
        $display("Checked %0d line records and %0d text summaries, %0d of them overflowed.",
                 lines_checked, texts_checked, rejected_texts);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/tlib_pkg.sv
rtl/core/tlib_front.sv
rtl/core/tlib_evq.sv
rtl/core/tlib_back.sv
rtl/core/text_line_index_builder.sv
sim/testbench.sv
